// ===== hw/rtl/tar_hc_pkg.sv =====
// -----------------------------------------------------------------------------
// tar_hc_pkg: shared constants and types for the tar header checker
// Record layout, octal field table, status codes and the tracker struct.
// -----------------------------------------------------------------------------
`default_nettype none

package tar_hc_pkg;

   localparam int REC_LEN   = 512;
   localparam int POS_W     = $clog2(REC_LEN);
   localparam int BYTE_W    = 8;
   localparam int SUM_W     = 17;
   localparam int SHORT_W   = 24;
   localparam int LONG_W    = 36;
   localparam int DIGIT_W   = 3;
   localparam int NFIELDS   = 5;
   localparam int STATUS_W  = 2;

   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(REC_LEN - 1);
   localparam logic [POS_W-1:0]  CK_START  = POS_W'(148);
   localparam logic [POS_W-1:0]  CK_END    = POS_W'(148 + 8);
   localparam logic [POS_W-1:0]  TYPE_POS  = POS_W'(156);
   localparam logic [SUM_W-1:0]  SUM_INIT  = SUM_W'(8 * 32);
   localparam logic [BYTE_W-1:0] NUL_CHAR  = 8'h00;

   // field indexes
   localparam int FLD_CK    = 0;
   localparam int FLD_MODE  = 1;
   localparam int FLD_OWNER = 2;
   localparam int FLD_SIZE  = 3;
   localparam int FLD_TIME  = 4;

   localparam logic [POS_W-1:0] FLD_START [NFIELDS] = '{
      POS_W'(148), POS_W'(100), POS_W'(108), POS_W'(124), POS_W'(136)
   };
   localparam logic [POS_W-1:0] FLD_LEN [NFIELDS] = '{
      POS_W'(8), POS_W'(8), POS_W'(8), POS_W'(12), POS_W'(12)
   };

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_CKSUM  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FIELD_FAIL = 2'd3;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic              last;
      logic              null_rec;
      logic [BYTE_W-1:0] entry_type;
      logic [SUM_W-1:0]  sum_in;
   } tar_hc_track_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tar_hc_req_if.sv =====
// -----------------------------------------------------------------------------
// tar_hc_req_if: request channel, one record byte per transaction
// Valid/ready handshake carrying the raw header byte.
// -----------------------------------------------------------------------------
`default_nettype none

interface tar_hc_req_if import tar_hc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] record_byte;

   modport source (output valid, output record_byte, input ready);
   modport sink   (input valid, input record_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tar_hc_rsp_if.sv =====
// -----------------------------------------------------------------------------
// tar_hc_rsp_if: response channel, one parsed header per transaction
// Valid/ready handshake carrying status and the parsed header fields.
// -----------------------------------------------------------------------------
`default_nettype none

interface tar_hc_rsp_if import tar_hc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SHORT_W-1:0]  mode_bits;
   logic [SHORT_W-1:0]  owner_id;
   logic [LONG_W-1:0]   file_size;
   logic [LONG_W-1:0]   mod_time;
   logic [BYTE_W-1:0]   entry_type;
   logic [SUM_W-1:0]    computed_sum;

   modport source (output valid, output status, output mode_bits, output owner_id,
                   output file_size, output mod_time, output entry_type,
                   output computed_sum, input ready);
   modport sink   (input valid, input status, input mode_bits, input owner_id,
                   input file_size, input mod_time, input entry_type,
                   input computed_sum, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tar_hc_track.sv =====
// -----------------------------------------------------------------------------
// tar_hc_track: record position, checksum sum, null mark and type byte
// Advances once per accepted byte; returns to its idle values after the last.
// -----------------------------------------------------------------------------
`default_nettype none

module tar_hc_track import tar_hc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] rec_byte,
   output tar_hc_track_type       track
);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              null_ff, null_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic              in_ck;
   logic              last;

   assign in_ck = (pos_ff >= CK_START) && (pos_ff < CK_END);
   assign last  = (pos_ff == LAST_POS);

   always_comb begin
      sum_in  = in_ck ? sum_ff : sum_ff + SUM_W'(rec_byte);
      null_in = null_ff | ((pos_ff == CK_START) && (rec_byte == NUL_CHAR));
      type_in = (pos_ff == TYPE_POS) ? rec_byte : type_ff;
      pos_in  = pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sum_ff  <= SUM_INIT;
         null_ff <= 1'b0;
         type_ff <= '0;
      end else if (step) begin
         if (last) begin
            pos_ff  <= '0;
            sum_ff  <= SUM_INIT;
            null_ff <= 1'b0;
            type_ff <= '0;
         end else begin
            pos_ff  <= pos_in;
            sum_ff  <= sum_in;
            null_ff <= null_in;
            type_ff <= type_in;
         end
      end
   end

   // byte 511 lies outside every field, so only the sum sees it
   assign track.pos        = pos_ff;
   assign track.last       = last;
   assign track.null_rec   = null_ff;
   assign track.entry_type = type_ff;
   assign track.sum_in     = sum_in;

endmodule

`default_nettype wire

// ===== hw/rtl/tar_hc_field.sv =====
// -----------------------------------------------------------------------------
// tar_hc_field: octal field parser
// Accumulates the leading run of octal digits inside one field window.
// -----------------------------------------------------------------------------
`default_nettype none

module tar_hc_field import tar_hc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [POS_W-1:0]  pos,
   input  wire logic [BYTE_W-1:0] rec_byte,
   input  wire logic [POS_W-1:0]  fld_start,
   input  wire logic [POS_W-1:0]  fld_len,
   output logic [LONG_W-1:0]      value,
   output logic                   bad
);

   logic [LONG_W-1:0] value_ff;
   logic              act_ff;
   logic              bad_ff;
   logic              in_field;
   logic              first;
   logic              digit;

   assign in_field = (pos >= fld_start) && (pos < fld_start + fld_len);
   assign first    = (pos == fld_start);
   assign digit    = rec_byte inside {["0":"7"]};

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         bad_ff <= 1'b0;
      end else if (step && in_field) begin
         if (first) begin
            act_ff <= digit;
            bad_ff <= !digit;
         end else if (act_ff && !digit) begin
            act_ff <= 1'b0;
         end
      end
   end

   // a run never exceeds 12 digits, which fill 36 bits, so no overflow
   always_ff @(posedge clock) begin
      if (step && in_field) begin
         if (first) begin
            value_ff <= digit ? LONG_W'(rec_byte[DIGIT_W-1:0]) : '0;
         end else if (act_ff && digit) begin
            value_ff <= {value_ff[LONG_W-DIGIT_W-1:0], rec_byte[DIGIT_W-1:0]};
         end
      end
   end

   assign value = value_ff;
   assign bad   = bad_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tar_hc_result.sv =====
// -----------------------------------------------------------------------------
// tar_hc_result: status decision and response register
// Grades the finished record and holds the response until it is taken.
// -----------------------------------------------------------------------------
`default_nettype none

module tar_hc_result import tar_hc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire tar_hc_track_type       track,
   input  wire logic [LONG_W-1:0]      fld_value [NFIELDS],
   input  wire logic [NFIELDS-1:0]     fld_bad,
   output logic                        slot_free,
   tar_hc_rsp_if.source                rsp
);

   logic                valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SHORT_W-1:0]  mode_ff, owner_ff;
   logic [LONG_W-1:0]   size_ff, time_ff;
   logic [BYTE_W-1:0]   type_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic                ok;

   always_comb begin
      if (track.null_rec) begin
         status_in = ST_NULL;
      end else if (fld_bad[FLD_CK] ||
                   fld_value[FLD_CK][SHORT_W-1:0] != SHORT_W'(track.sum_in)) begin
         status_in = ST_BAD_CKSUM;
      end else if (fld_bad[NFIELDS-1:FLD_MODE] != '0) begin
         status_in = ST_FIELD_FAIL;
      end else begin
         status_in = ST_OK;
      end
   end

   assign ok        = (status_in == ST_OK);
   assign slot_free = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         mode_ff   <= ok ? fld_value[FLD_MODE][SHORT_W-1:0] : '0;
         owner_ff  <= ok ? fld_value[FLD_OWNER][SHORT_W-1:0] : '0;
         size_ff   <= ok ? fld_value[FLD_SIZE] : '0;
         time_ff   <= ok ? fld_value[FLD_TIME] : '0;
         type_ff   <= track.entry_type;
         sum_ff    <= track.sum_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.mode_bits    = mode_ff;
   assign rsp.owner_id     = owner_ff;
   assign rsp.file_size    = size_ff;
   assign rsp.mod_time     = time_ff;
   assign rsp.entry_type   = type_ff;
   assign rsp.computed_sum = sum_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tar_header_check_parse.sv =====
// The response is registered and valid in the cycle after byte 511 is taken.
// Throughput: one record byte per cycle, including across records, save as below.
// The last byte of a record waits only if the previous response is still held;
// every other byte is taken at once, so a stalled response blocks one byte.
// Reset (synchronous, active high): position 0, sum at its eight-space seed,
// all field flags clear, no response pending.
// -----------------------------------------------------------------------------
// tar_header_check_parse: streaming tar header checksum check and field parse
// Sums the record, parses five octal fields and grades the header.
// -----------------------------------------------------------------------------
`default_nettype none

module tar_header_check_parse import tar_hc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   tar_hc_req_if.sink   req_if,
   tar_hc_rsp_if.source rsp_if
);

   tar_hc_track_type   track;
   logic [LONG_W-1:0]  fld_value [NFIELDS];
   logic [NFIELDS-1:0] fld_bad;
   logic               slot_free;
   logic               req_fire;
   logic               load;

   // Only the closing byte needs the response slot; everything else streams in.
   assign req_if.ready = !track.last || slot_free;
   assign req_fire     = req_if.valid && req_if.ready;
   assign load         = req_fire && track.last;

   // Position counter, running checksum sum, null mark and type byte.
   tar_hc_track u_track (
      .clock    (clock),
      .reset    (reset),
      .step     (req_fire),
      .rec_byte (req_if.record_byte),
      .track    (track)
   );

   // One parser per octal field: checksum, mode, owner, size, mtime.
   for (genvar f = 0; f < NFIELDS; f++) begin : g_field
      tar_hc_field u_field (
         .clock     (clock),
         .reset     (reset),
         .step      (req_fire),
         .pos       (track.pos),
         .rec_byte  (req_if.record_byte),
         .fld_start (FLD_START[f]),
         .fld_len   (FLD_LEN[f]),
         .value     (fld_value[f]),
         .bad       (fld_bad[f])
      );
   end

   // Grades the record on its last byte and registers the response.
   tar_hc_result u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .track     (track),
      .fld_value (fld_value),
      .fld_bad   (fld_bad),
      .slot_free (slot_free),
      .rsp       (rsp_if)
   );

   // ---- checks ----

   // closing byte always produces a response on the next cycle
   a_load_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_if.valid)
      else $error("closing transaction did not produce a response");

   // position wraps to the record start after the closing byte
   a_pos_wraps: assert property (@(posedge clock) disable iff (reset)
      load |=> (track.pos == '0))
      else $error("position did not wrap after record end");

   // input only stalls on the closing byte behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (track.last && rsp_if.valid && !rsp_if.ready))
      else $error("request stalled without a pending response");

   // value fields are zero on any non-success status
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != ST_OK) |->
         (rsp_if.mode_bits == '0 && rsp_if.owner_id == '0 &&
          rsp_if.file_size == '0 && rsp_if.mod_time == '0))
      else $error("nonzero value fields on failing status");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb: self-checking bench for tar_header_check_parse
// Streams whole 512-byte header records, one byte per request transaction,
// predicts the graded header for each record and compares every response
// field by field. A directed table of hand-built records comes first, then
// randomly built records, mostly well formed, some broken.
// -----------------------------------------------------------------------------
module tb;
   import tar_hc_pkg::*;

   localparam int RAND_RECORDS   = 48;
   localparam int DIR_ROWS       = 15;
   localparam int STALL_PCT      = 7;     // idle chance per cycle, each side
   localparam int QUIET_FIRST    = 8;     // random records run with no idling
   localparam int QUIET_LAST     = 14;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 8;
   localparam int MAX_REPORTS    = 10;

   localparam logic [BYTE_W-1:0] CH_ZERO  = "0";
   localparam logic [BYTE_W-1:0] CH_SEVEN = "7";
   localparam logic [BYTE_W-1:0] CH_SPACE = " ";

   // background bytes of a record before the fields go in
   typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SPACE} fill_kind_type;

   // how the checksum field is written
   typedef enum logic [2:0] {
      CK_GOOD,        // six digits, NUL, space
      CK_GOOD_FULL,   // eight digits, leading zeros
      CK_WRONG,       // six digits of a sum with one bit flipped
      CK_NULL,        // good digits, first byte NUL
      CK_NOT_DIGIT,   // good digits, first byte a nonzero non-octal char
      CK_UNTOUCHED    // leave the fill bytes as they are
   } ck_kind_type;

   typedef struct packed {
      fill_kind_type       fill;
      ck_kind_type         ck;
      logic [SHORT_W-1:0]  mode_v;
      logic [3:0]          nd_mode;    // digit count; 0 puts term first
      logic [SHORT_W-1:0]  owner_v;
      logic [3:0]          nd_owner;
      logic [LONG_W-1:0]   size_v;
      logic [3:0]          nd_size;
      logic [LONG_W-1:0]   mtime_v;
      logic [3:0]          nd_mtime;
      logic [BYTE_W-1:0]   term;       // byte that ends each short digit run
      logic [BYTE_W-1:0]   etype;
      logic                pin;        // status typed in below
      logic [STATUS_W-1:0] pin_status;
   } rec_spec_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SHORT_W-1:0]  mode_bits;
      logic [SHORT_W-1:0]  owner_id;
      logic [LONG_W-1:0]   file_size;
      logic [LONG_W-1:0]   mod_time;
      logic [BYTE_W-1:0]   entry_type;
      logic [SUM_W-1:0]    computed_sum;
   } hdr_result_type;

   // Directed records. Status is typed in where it is obvious from the
   // record; every other field of every row comes from the predictor.
   rec_spec_type dir_rows [DIR_ROWS] = '{
      // all-zero background, single '0' digit in every value field
      '{FILL_ZERO, CK_GOOD, 24'o0, 4'd1, 24'o0, 4'd1, 36'o0, 4'd1, 36'o0, 4'd1,
        8'h00, 8'h00, 1'b1, ST_OK},
      // every value field full width of 7s, all-ones background, max-ish sum
      '{FILL_ONES, CK_GOOD_FULL, 24'o77777777, 4'd8, 24'o77777777, 4'd8,
        36'o777777777777, 4'd12, 36'o777777777777, 4'd12, 8'hFF, 8'hFF, 1'b1, ST_OK},
      // ordinary header, NUL-terminated fields
      '{FILL_SPACE, CK_GOOD, 24'o644, 4'd7, 24'o1750, 4'd7, 36'o1234, 4'd11,
        36'o14353172645, 4'd11, 8'h00, "0", 1'b0, ST_OK},
      // null record over random content
      '{FILL_RANDOM, CK_NULL, 24'o644, 4'd7, 24'o1750, 4'd7, 36'o1234, 4'd11,
        36'o14353172645, 4'd11, 8'h00, "0", 1'b1, ST_NULL},
      // null record wins over a failing mode field
      '{FILL_ONES, CK_NULL, 24'o644, 4'd0, 24'o1750, 4'd7, 36'o1234, 4'd11,
        36'o14353172645, 4'd11, "8", "5", 1'b1, ST_NULL},
      // checksum field not a number
      '{FILL_SPACE, CK_NOT_DIGIT, 24'o644, 4'd7, 24'o1750, 4'd7, 36'o1234, 4'd11,
        36'o14353172645, 4'd11, 8'h00, "0", 1'b1, ST_BAD_CKSUM},
      // checksum off by one bit
      '{FILL_RANDOM, CK_WRONG, 24'o755, 4'd7, 24'o0, 4'd7, 36'o77, 4'd11,
        36'o1, 4'd11, 8'h00, "2", 1'b1, ST_BAD_CKSUM},
      // bad checksum wins over a failing owner field
      '{FILL_ZERO, CK_WRONG, 24'o755, 4'd7, 24'o1, 4'd0, 36'o77, 4'd11,
        36'o1, 4'd11, "/", "2", 1'b1, ST_BAD_CKSUM},
      // mode starts with '8'
      '{FILL_SPACE, CK_GOOD, 24'o644, 4'd0, 24'o1750, 4'd7, 36'o1234, 4'd11,
        36'o1, 4'd11, "8", "0", 1'b1, ST_FIELD_FAIL},
      // owner starts with '/'
      '{FILL_RANDOM, CK_GOOD_FULL, 24'o644, 4'd7, 24'o1750, 4'd0, 36'o1234, 4'd11,
        36'o1, 4'd11, "/", "0", 1'b1, ST_FIELD_FAIL},
      // size starts with a space
      '{FILL_ZERO, CK_GOOD, 24'o644, 4'd7, 24'o1750, 4'd7, 36'o1234, 4'd0,
        36'o1, 4'd11, CH_SPACE, "0", 1'b1, ST_FIELD_FAIL},
      // mtime starts with NUL
      '{FILL_ONES, CK_GOOD, 24'o644, 4'd7, 24'o1750, 4'd7, 36'o1234, 4'd11,
        36'o1, 4'd0, 8'h00, "0", 1'b1, ST_FIELD_FAIL},
      // short runs ended by '9', random bytes behind them
      '{FILL_RANDOM, CK_GOOD, 24'o123, 4'd3, 24'o456, 4'd3, 36'o701, 4'd3,
        36'o17, 4'd3, "9", "5", 1'b0, ST_OK},
      // noise background, zero-digit value fields, checksum left as noise
      '{FILL_RANDOM, CK_UNTOUCHED, 24'o0, 4'd8, 24'o0, 4'd8, 36'o0, 4'd12,
        36'o0, 4'd12, 8'hFF, 8'h80, 1'b0, ST_OK},
      // alternating 7/0 digits across full fields
      '{FILL_RANDOM, CK_GOOD_FULL, 24'o70707070, 4'd8, 24'o07070707, 4'd8,
        36'o707070707070, 4'd12, 36'o070707070707, 4'd12, 8'hFF, "7", 1'b0, ST_OK}
   };

   logic clock;
   logic reset;

   tar_hc_req_if req_ch ();
   tar_hc_rsp_if rsp_ch ();

   tar_header_check_parse uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // ---------------------------------------------------------------------------
   // Header predictor state: mirrors the block's tracker for the record being
   // streamed. One digit accumulator per octal field, indexed by FLD_*.
   // ---------------------------------------------------------------------------
   logic [POS_W-1:0]   trk_pos;
   logic [SUM_W-1:0]   trk_sum;
   logic [LONG_W-1:0]  fld_acc [NFIELDS];
   logic [NFIELDS-1:0] run_open;   // digit run still going
   logic [NFIELDS-1:0] lead_bad;   // first byte of field was not octal
   logic               null_seen;
   logic [BYTE_W-1:0]  kept_type;

   hdr_result_type hdr_expect_q [$];  // graded headers waiting for the response
   hdr_result_type want;

   logic [BYTE_W-1:0]   rec_bytes [REC_LEN];
   logic                pin_on;
   logic [STATUS_W-1:0] pin_code;
   logic                gaps_on;

   int mismatches;
   int results_seen;
   int bytes_sent;
   int records_sent;
   int stuck_cycles;
   int status_tally [4];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic clear_tracker();
      trk_pos   = '0;
      trk_sum   = SUM_INIT;
      run_open  = '0;
      lead_bad  = '0;
      null_seen = 1'b0;
      kept_type = '0;
      for (int f = 0; f < NFIELDS; f++)
         fld_acc[f] = '0;
   endtask

   // Advance the predictor by one accepted byte; on the last byte of the
   // record hand back the graded header and rewind for the next record.
   task automatic grade_byte(input logic [BYTE_W-1:0] b, output logic done,
                             output hdr_result_type r);
      logic [POS_W-1:0]  rel;
      logic [LONG_W-1:0] lane_mask;
      logic              is_oct;
      is_oct = (b >= CH_ZERO) && (b <= CH_SEVEN);
      done = 1'b0;
      r = '0;
      // checksum bytes themselves stay out of the sum
      if (trk_pos < CK_START || trk_pos >= CK_END)
         trk_sum = trk_sum + SUM_W'(b);
      for (int f = 0; f < NFIELDS; f++) begin
         if (trk_pos >= FLD_START[f] && trk_pos < FLD_START[f] + FLD_LEN[f]) begin
            rel = trk_pos - FLD_START[f];
            lane_mask = (f < FLD_SIZE) ? {{(LONG_W-SHORT_W){1'b0}}, {SHORT_W{1'b1}}}
                                       : {LONG_W{1'b1}};
            // '0'..'7' carry their digit value in the low three bits
            if (rel == '0) begin
               run_open[f] = is_oct;
               lead_bad[f] = !is_oct;
               fld_acc[f]  = is_oct ? LONG_W'(b[DIGIT_W-1:0]) : '0;
            end else if (run_open[f]) begin
               if (is_oct)
                  fld_acc[f] = ((fld_acc[f] << DIGIT_W) | LONG_W'(b[DIGIT_W-1:0]))
                               & lane_mask;
               else
                  run_open[f] = 1'b0;
            end
         end
      end
      if (trk_pos == CK_START && b == NUL_CHAR)
         null_seen = 1'b1;
      if (trk_pos == TYPE_POS)
         kept_type = b;
      if (trk_pos != LAST_POS) begin
         trk_pos = trk_pos + 1'b1;
      end else begin
         done = 1'b1;
         // grading order: null, checksum, other fields
         if (null_seen)
            r.status = ST_NULL;
         else if (lead_bad[FLD_CK] || fld_acc[FLD_CK] != LONG_W'(trk_sum))
            r.status = ST_BAD_CKSUM;
         else if (lead_bad[FLD_TIME:FLD_MODE] != '0)
            r.status = ST_FIELD_FAIL;
         else
            r.status = ST_OK;
         if (r.status == ST_OK) begin
            r.mode_bits = fld_acc[FLD_MODE][SHORT_W-1:0];
            r.owner_id  = fld_acc[FLD_OWNER][SHORT_W-1:0];
            r.file_size = fld_acc[FLD_SIZE];
            r.mod_time  = fld_acc[FLD_TIME];
         end
         r.entry_type   = kept_type;
         r.computed_sum = trk_sum;
         clear_tracker();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Record builder
   // ---------------------------------------------------------------------------
   function automatic logic [BYTE_W-1:0] rand_non_octal(input logic allow_nul);
      logic [BYTE_W-1:0] b;
      do
         b = BYTE_W'($urandom_range(255));
      while ((b >= CH_ZERO && b <= CH_SEVEN) || (!allow_nul && b == NUL_CHAR));
      return b;
   endfunction

   // nd octal digits of v, most significant first, then term if room is left
   task automatic put_octal(input int start, input int len, input logic [LONG_W-1:0] v,
                            input int nd, input logic [BYTE_W-1:0] term);
      for (int k = 0; k < nd; k++)
         rec_bytes[start + k] = CH_ZERO + BYTE_W'(3'(v >> (DIGIT_W * (nd - 1 - k))));
      if (nd < len)
         rec_bytes[start + nd] = term;
   endtask

   task automatic build_record(input rec_spec_type s);
      logic [SUM_W-1:0] sum;
      for (int i = 0; i < REC_LEN; i++) begin
         case (s.fill)
            FILL_ZERO:  rec_bytes[i] = 8'h00;
            FILL_ONES:  rec_bytes[i] = 8'hFF;
            FILL_SPACE: rec_bytes[i] = CH_SPACE;
            default:    rec_bytes[i] = BYTE_W'($urandom_range(255));
         endcase
      end
      put_octal(FLD_START[FLD_MODE],  FLD_LEN[FLD_MODE],  LONG_W'(s.mode_v),  s.nd_mode,  s.term);
      put_octal(FLD_START[FLD_OWNER], FLD_LEN[FLD_OWNER], LONG_W'(s.owner_v), s.nd_owner, s.term);
      put_octal(FLD_START[FLD_SIZE],  FLD_LEN[FLD_SIZE],  s.size_v,  s.nd_size,  s.term);
      put_octal(FLD_START[FLD_TIME],  FLD_LEN[FLD_TIME],  s.mtime_v, s.nd_mtime, s.term);
      rec_bytes[TYPE_POS] = s.etype;

      sum = SUM_INIT;
      for (int i = 0; i < REC_LEN; i++)
         if (i < CK_START || i >= CK_END)
            sum = sum + SUM_W'(rec_bytes[i]);

      case (s.ck)
         CK_GOOD_FULL:
            put_octal(CK_START, FLD_LEN[FLD_CK], LONG_W'(sum), FLD_LEN[FLD_CK], NUL_CHAR);
         CK_WRONG: begin
            put_octal(CK_START, FLD_LEN[FLD_CK],
                      LONG_W'(sum ^ (SUM_W'(1) << $urandom_range(SUM_W - 1))), 6, NUL_CHAR);
            rec_bytes[CK_END - 1'b1] = CH_SPACE;
         end
         CK_UNTOUCHED: ;
         default: begin
            put_octal(CK_START, FLD_LEN[FLD_CK], LONG_W'(sum), 6, NUL_CHAR);
            rec_bytes[CK_END - 1'b1] = CH_SPACE;
         end
      endcase
      if (s.ck == CK_NULL)
         rec_bytes[CK_START] = NUL_CHAR;
      if (s.ck == CK_NOT_DIGIT)
         rec_bytes[CK_START] = rand_non_octal(1'b0);
   endtask

   // Mostly well-formed headers with random content; the rest broken in one
   // way or another so every grading path keeps getting hit.
   function automatic rec_spec_type rand_spec();
      rec_spec_type s;
      int roll;
      roll = $urandom_range(99);
      if (roll < 70)      s.fill = FILL_RANDOM;
      else if (roll < 80) s.fill = FILL_ZERO;
      else if (roll < 90) s.fill = FILL_ONES;
      else                s.fill = FILL_SPACE;
      s.mode_v     = SHORT_W'($urandom);
      s.owner_v    = SHORT_W'($urandom);
      s.size_v     = LONG_W'({$urandom, $urandom});
      s.mtime_v    = LONG_W'({$urandom, $urandom});
      s.nd_mode    = 4'($urandom_range(1, 8));
      s.nd_owner   = 4'($urandom_range(1, 8));
      s.nd_size    = 4'($urandom_range(1, 12));
      s.nd_mtime   = 4'($urandom_range(1, 12));
      s.term       = rand_non_octal(1'b1);
      s.etype      = BYTE_W'($urandom_range(255));
      s.pin        = 1'b0;
      s.pin_status = ST_OK;
      s.ck         = $urandom_range(1) ? CK_GOOD : CK_GOOD_FULL;
      if ($urandom_range(99) >= 75) begin
         case ($urandom_range(4))
            0: s.ck = CK_WRONG;
            1: s.ck = CK_NULL;
            2: s.ck = CK_NOT_DIGIT;
            3: case ($urandom_range(3))
                  0:       s.nd_mode  = '0;
                  1:       s.nd_owner = '0;
                  2:       s.nd_size  = '0;
                  default: s.nd_mtime = '0;
               endcase
            default: s.ck = CK_UNTOUCHED;
         endcase
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side: one byte per transaction, driven on the falling edge.
   // ---------------------------------------------------------------------------
   task automatic push_byte(input logic [BYTE_W-1:0] b);
      hdr_result_type r;
      logic           done;
      while (gaps_on && $urandom_range(99) < STALL_PCT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.record_byte = b;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      grade_byte(b, done, r);
      if (done) begin
         // typed-in status overrides the predicted one for pinned rows
         if (pin_on) begin
            r.status = pin_code;
            if (pin_code != ST_OK) begin
               r.mode_bits = '0;
               r.owner_id  = '0;
               r.file_size = '0;
               r.mod_time  = '0;
            end
         end
         hdr_expect_q.push_back(r);
      end
      @(negedge clock);
   endtask

   task automatic stream_record(input rec_spec_type s);
      build_record(s);
      pin_on   = s.pin;
      pin_code = s.pin_status;
      for (int i = 0; i < REC_LEN; i++)
         push_byte(rec_bytes[i]);
      records_sent++;
   endtask

   // sender holds off until every graded header has come back
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (hdr_expect_q.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random backpressure, changed on the falling edge.
   // ---------------------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = !(gaps_on && $urandom_range(99) < STALL_PCT);
      end
   end

   task automatic check_field(input string tag, input logic [LONG_W-1:0] exp_v,
                              input logic [LONG_W-1:0] act_v);
      if (act_v !== exp_v) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("record %0d: %s mismatch, expected 0x%0h, got 0x%0h",
                     results_seen, tag, exp_v, act_v);
      end
   endtask

   // Every accepted response is matched against the oldest graded header.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (hdr_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("record %0d: response transaction with no record pending",
                        results_seen);
         end else begin
            want = hdr_expect_q.pop_front();
            status_tally[want.status]++;
            check_field("status",       LONG_W'(want.status),       LONG_W'(rsp_ch.status));
            check_field("mode_bits",    LONG_W'(want.mode_bits),    LONG_W'(rsp_ch.mode_bits));
            check_field("owner_id",     LONG_W'(want.owner_id),     LONG_W'(rsp_ch.owner_id));
            check_field("file_size",    want.file_size,             rsp_ch.file_size);
            check_field("mod_time",     want.mod_time,              rsp_ch.mod_time);
            check_field("entry_type",   LONG_W'(want.entry_type),   LONG_W'(rsp_ch.entry_type));
            check_field("computed_sum", LONG_W'(want.computed_sum), LONG_W'(rsp_ch.computed_sum));
         end
      end
   end

   // Watchdog: too long with no transaction on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a transaction", stuck_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.record_byte = '0;
      gaps_on            = 1'b1;
      pin_on             = 1'b0;
      pin_code           = ST_OK;
      mismatches         = 0;
      results_seen       = 0;
      bytes_sent         = 0;
      records_sent       = 0;
      stuck_cycles       = 0;
      status_tally       = '{default: 0};
      clear_tracker();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (int i = 0; i < DIR_ROWS; i++)
         stream_record(dir_rows[i]);
      wait_drained();

      // random records; a run of them with both sides never idling, and
      // now and then a full drain between records
      for (int i = 0; i < RAND_RECORDS; i++) begin
         gaps_on = !(i >= QUIET_FIRST && i < QUIET_LAST);
         stream_record(rand_spec());
         if ($urandom_range(3) == 0)
            wait_drained();
      end
      gaps_on = 1'b1;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("streamed %0d records in %0d byte transactions, %0d responses checked",
               records_sent, bytes_sent, results_seen);
      $display("graded: %0d ok, %0d null, %0d bad checksum, %0d field failure; %0d mismatches",
               status_tally[ST_OK], status_tally[ST_NULL], status_tally[ST_BAD_CKSUM],
               status_tally[ST_FIELD_FAIL], mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
